// ===== rtl/rms_level_db_meter_unit_macros.svh =====
// ---------------------------------------------------------------------------
// rms level meter assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef RMS_LEVEL_DB_METER_UNIT_MACROS_SVH
`define RMS_LEVEL_DB_METER_UNIT_MACROS_SVH

// same-cycle implication
`define RLM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rlm assertion failed");

// next-cycle implication
`define RLM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rlm assertion failed");

`endif

// ===== rtl/rlm_pkg.sv =====
// ---------------------------------------------------------------------------
// rlm_pkg
// widths, level threshold table and token type of the rms level meter
// ---------------------------------------------------------------------------
package rlm_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int SQUARE_W   = 15;
  localparam int SQUARE_MAX = 32767;
  localparam int LEVEL_W    = 7;

  // reciprocal scaling used for the divide by the window root
  localparam int RECIP_SHIFT = 20;

  localparam int NUM_THRESH = 55;
  localparam int LVL_CNT_W  = $clog2(NUM_THRESH + 1);
  // sum width at the largest window (64 entries)
  localparam int LVL_SUM_W  = 21;

  localparam logic [SAMPLE_W-1:0] MIDSCALE_RESET = 10'd512;
  localparam logic signed [LEVEL_W-1:0] SILENT_LEVEL = -7'sd8;

  // level L holds when sum >= ceil(6.25 * 10^(L/10))
  localparam logic [LVL_SUM_W-1:0] DB_THRESH [NUM_THRESH] = '{
    21'd8, 21'd10, 21'd13, 21'd16, 21'd20, 21'd25, 21'd32, 21'd40, 21'd50, 21'd63,
    21'd79, 21'd100, 21'd125, 21'd157, 21'd198, 21'd249, 21'd314, 21'd395, 21'd497,
    21'd625, 21'd787, 21'd991, 21'd1248, 21'd1570, 21'd1977, 21'd2489, 21'd3133,
    21'd3944, 21'd4965, 21'd6250, 21'd7869, 21'd9906, 21'd12471, 21'd15700,
    21'd19765, 21'd24882, 21'd31325, 21'd39435, 21'd49646, 21'd62500, 21'd78683,
    21'd99056, 21'd124704, 21'd156993, 21'd197643, 21'd248817, 21'd313243,
    21'd394349, 21'd496456, 21'd625000, 21'd786829, 21'd990559, 21'd1247039,
    21'd1569930, 21'd1976424
  };

  typedef struct packed {
    logic                 valid;
    logic [LVL_SUM_W-1:0] sum;
    logic [LVL_CNT_W-1:0] count;
  } lvl_token_t;

  // levels for sums below the first threshold
  function automatic logic signed [LEVEL_W-1:0] small_level(input logic [2:0] s);
    logic signed [LEVEL_W-1:0] lvl;
    case (s)
      3'd0:    lvl = SILENT_LEVEL;
      3'd1:    lvl = -7'sd7;
      3'd2:    lvl = -7'sd4;
      3'd3:    lvl = -7'sd3;
      3'd4:    lvl = -7'sd1;
      default: lvl = 7'sd0;
    endcase
    return lvl;
  endfunction

endpackage

// ===== rtl/rlm_if.sv =====
// ---------------------------------------------------------------------------
// rlm channel interfaces
// valid/ready channels for samples, results and the midscale write
// ---------------------------------------------------------------------------
interface rlm_sample_if;
  import rlm_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

interface rlm_result_if;
  import rlm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [LEVEL_W-1:0] level_db;
  logic                      silent;
  modport source(output valid, output level_db, output silent, input ready);
  modport sink(input valid, input level_db, input silent, output ready);
endinterface

interface rlm_cfg_if;
  import rlm_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] midscale;
  modport source(output valid, output midscale, input ready);
  modport sink(input valid, input midscale, output ready);
endinterface

// ===== rtl/rms_level_db_meter_unit.sv =====
// ---------------------------------------------------------------------------
// rms_level_db_meter_unit
// moving-window rms level meter giving whole decibels once per window
// ---------------------------------------------------------------------------
//  channel   dir  word                     handshake
//  cfg       in   midscale [9:0]           valid/ready, ready always high
//  samples   in   sample [9:0]             valid/ready
//  results   out  level_db [6:0], silent   valid/ready, one per window
//
//  one sample per cycle unless the pipe holds; a result follows every WINDOW_ROOT^2 samples
//  from sample to result the data passes the front stages, the chain of level
//  cells (one threshold per cell) and the output register
//  reset clears the window cells, the sum, the slot count and all valid bits
//  the whole pipe holds only when the last level cell has a result and the
//  output register is still full and not taken
// ---------------------------------------------------------------------------
`include "rms_level_db_meter_unit_macros.svh"

module rms_level_db_meter_unit #(
  parameter int WINDOW_ROOT = 4
) (
  input  logic          clk,
  input  logic          rst,
  rlm_cfg_if.sink       cfg,
  rlm_sample_if.sink    samples,
  rlm_result_if.source  results
);
  import rlm_pkg::*;

  localparam int WIN_LEN = WINDOW_ROOT * WINDOW_ROOT;
  localparam int CNT_W   = $clog2(WIN_LEN);
  localparam int SUM_MAX = WIN_LEN * SQUARE_MAX;
  localparam int SUM_W   = $clog2(SUM_MAX + 1);
  localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(WIN_LEN - 1);

  logic [SAMPLE_W-1:0] midscale;
  logic                adv;
  logic                sq_valid;
  logic [SQUARE_W-1:0] sq;
  logic [SQUARE_W-1:0] ring_q [WIN_LEN];
  logic                ring_shift;
  logic [SUM_W-1:0]    window_sum;
  logic [SUM_W-1:0]    window_sum_next;
  logic [CNT_W-1:0]    ring_count;
  lvl_token_t          tok [NUM_THRESH+1];
  lvl_token_t          tok_last;
  logic                out_load;
  logic                tok_small;

  // midscale register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      midscale <= MIDSCALE_RESET;
    end else if (cfg.valid) begin
      midscale <= cfg.midscale;
    end
  end

  // stall only when a finished level has nowhere to go
  assign adv           = !(tok_last.valid && results.valid && !results.ready);
  assign samples.ready = adv;

  rlm_square_front #(
    .WINDOW_ROOT(WINDOW_ROOT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (samples.valid),
    .sample   (samples.sample),
    .midscale (midscale),
    .sq_valid (sq_valid),
    .sq       (sq)
  );

  // window cells, last cell holds the oldest square
  assign ring_shift = adv && sq_valid;

  for (genvar i = 0; i < WIN_LEN; i++) begin : g_ring
    rlm_ring_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ring_shift),
      .d     ((i == 0) ? sq : ring_q[(i == 0) ? 0 : i-1]),
      .q     (ring_q[i])
    );
  end

  assign window_sum_next = window_sum - SUM_W'(ring_q[WIN_LEN-1]) + SUM_W'(sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
      ring_count <= '0;
    end else if (ring_shift) begin
      window_sum <= window_sum_next;
      ring_count <= (ring_count == LAST_SLOT) ? '0 : ring_count + 1'b1;
    end
  end

  // a full window enters the level chain
  assign tok[0].valid = ring_shift && (ring_count == LAST_SLOT);
  assign tok[0].sum   = LVL_SUM_W'(window_sum_next);
  assign tok[0].count = '0;

  for (genvar k = 0; k < NUM_THRESH; k++) begin : g_level
    rlm_level_cell #(
      .INDEX(k)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .adv (adv),
      .d   (tok[k]),
      .q   (tok[k+1])
    );
  end

  assign tok_last  = tok[NUM_THRESH];
  assign tok_small = (tok_last.sum[LVL_SUM_W-1:3] == '0);
  assign out_load  = adv && tok_last.valid;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.level_db <= tok_small ? small_level(tok_last.sum[2:0])
                                    : $signed(LEVEL_W'(tok_last.count));
      results.silent   <= (tok_last.sum == '0);
    end
  end

  `RLM_ASSERT_IMP(a_silent_level, results.valid && results.silent, results.level_db == SILENT_LEVEL)
  `RLM_ASSERT_IMP(a_loud_level, results.valid && !results.silent, results.level_db != SILENT_LEVEL)
  `RLM_ASSERT_IMP(a_sum_bound, 1'b1, window_sum <= SUM_W'(SUM_MAX))
  `RLM_ASSERT_NXT(a_hold_sum, !adv, $stable(window_sum) && $stable(ring_count))
  `RLM_ASSERT_NXT(a_wrap_token, ring_shift && ring_count == LAST_SLOT, tok[1].valid)

endmodule

// ===== rtl/rlm_square_front.sv =====
// ---------------------------------------------------------------------------
// rlm_square_front
// offset removal, divide by window root and saturating square, three stages
// ---------------------------------------------------------------------------
module rlm_square_front #(
  parameter int WINDOW_ROOT = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [rlm_pkg::SAMPLE_W-1:0] sample,
  input  logic [rlm_pkg::SAMPLE_W-1:0] midscale,
  output logic                         sq_valid,
  output logic [rlm_pkg::SQUARE_W-1:0] sq
);
  import rlm_pkg::*;

  localparam int MAG_MAX = (1 << SAMPLE_W) - 1;
  localparam int QUOT_W  = $clog2(MAG_MAX / WINDOW_ROOT + 1);
  localparam int RECIP   = ((1 << RECIP_SHIFT) + WINDOW_ROOT - 1) / WINDOW_ROOT;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = SAMPLE_W + RECIP_W;
  localparam int SQF_W   = 2 * QUOT_W;
  localparam int CMP_W   = (SQF_W > SQUARE_W) ? SQF_W : SQUARE_W;

  logic [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]   diff_neg;
  logic [SAMPLE_W-1:0] mag;
  logic                mag_valid;
  logic [PROD_W-1:0]   prod;
  logic [QUOT_W-1:0]   quot;
  logic                quot_valid;
  logic [SQF_W-1:0]    sq_full;
  logic [CMP_W-1:0]    sq_ext;

  // sign drops out in the square, so only the magnitude is carried
  assign diff     = {1'b0, sample} - {1'b0, midscale};
  assign diff_neg = -diff;

  // ceil reciprocal is exact for every 10-bit magnitude at this shift
  assign prod     = PROD_W'(mag) * PROD_W'(RECIP);
  assign sq_full  = SQF_W'(quot) * SQF_W'(quot);
  assign sq_ext   = CMP_W'(sq_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid  <= 1'b0;
      quot_valid <= 1'b0;
      sq_valid   <= 1'b0;
    end else if (adv) begin
      mag_valid  <= in_valid;
      quot_valid <= mag_valid;
      sq_valid   <= quot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag  <= diff[SAMPLE_W] ? diff_neg[SAMPLE_W-1:0] : diff[SAMPLE_W-1:0];
      quot <= prod[RECIP_SHIFT +: QUOT_W];
      sq   <= (sq_ext > CMP_W'(SQUARE_MAX)) ? SQUARE_W'(SQUARE_MAX) : sq_ext[SQUARE_W-1:0];
    end
  end

endmodule

// ===== rtl/rlm_ring_cell.sv =====
// ---------------------------------------------------------------------------
// rlm_ring_cell
// one slot of the square window, shifts toward the oldest end per sample
// ---------------------------------------------------------------------------
module rlm_ring_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         shift,
  input  logic [rlm_pkg::SQUARE_W-1:0] d,
  output logic [rlm_pkg::SQUARE_W-1:0] q
);
  import rlm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== rtl/rlm_level_cell.sv =====
// ---------------------------------------------------------------------------
// rlm_level_cell
// one threshold compare of the level chain, bumps the count when passed
// ---------------------------------------------------------------------------
module rlm_level_cell #(
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  rlm_pkg::lvl_token_t d,
  output rlm_pkg::lvl_token_t q
);
  import rlm_pkg::*;

  localparam logic [LVL_SUM_W-1:0] THRESH = DB_THRESH[INDEX];

  logic pass;

  assign pass = (d.sum >= THRESH);

  // only the valid bit is reset, the payload follows it
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q.valid <= d.valid;
    end
    if (adv) begin
      q.sum   <= d.sum;
      q.count <= d.count + LVL_CNT_W'(pass);
    end
  end

endmodule
